// ===== src/stp_pkg.sv =====
// ============================================================================
// stp_pkg - shared types and constants of the step/dir pulse generator
// Command classes, sequencer phases, register map and divider constants.
// ============================================================================
package stp_pkg;

    // field widths fixed by the interface
    localparam int STEPS_W = 16;
    localparam int RPM_W   = 12;
    localparam int SPR_W   = 16;
    localparam int REM_W   = 16;
    localparam int OP_W    = 2;

    // defaults of the top-level parameters
    localparam int STEP_COUNT_BITS_DEF = 16;
    localparam int DIR_SETUP_TICKS_DEF = 10;

    // half period = HP_NUMER / (rpm * spr), floored at HP_MIN
    localparam int                HP_W     = 25;
    localparam int                DEN_W    = RPM_W + SPR_W;
    localparam logic [HP_W-1:0]   HP_NUMER = 25'd30000000;
    localparam logic [HP_W-1:0]   HP_MIN   = 25'd3;

    localparam logic [SPR_W-1:0]  SPR_RESET = 16'd200;

    // opcodes of the input beat
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_SPR    = 1'b0;
    localparam logic REG_DRV_EN = 1'b1;

    typedef enum logic [1:0] {
        K_TICK,
        K_MOVE,
        K_STOP,
        K_NONE
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETUP,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic {
        BS_WAIT,
        BS_DIV
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic [STEPS_W-1:0] steps;
        logic [RPM_W-1:0]   rpm;
    } t_cmd;

    typedef struct packed {
        logic [SPR_W-1:0] spr;
        logic             drv_en;
    } t_cfg;

endpackage

// ===== src/stp_front.sv =====
// ============================================================================
// stp_front - input classifier and two-entry command queue
// Decodes each beat into tick/move/stop/none and queues it for the back end.
// ============================================================================
module stp_front #(
    parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [stp_pkg::OP_W-1:0]    i_op,
    input  logic [stp_pkg::STEPS_W-1:0] i_steps,
    input  logic [stp_pkg::RPM_W-1:0]   i_rpm,
    output logic                        o_cmd_valid,
    output stp_pkg::t_cmd               o_cmd,
    input  logic                        i_take
);
    import stp_pkg::*;

    t_cmd                       r_mem [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_cnt;
    t_cmd                       cls;
    logic [STEP_COUNT_BITS-1:0] steps_t;
    logic                       wr, rd;

    // zero test on the count as the back end will see it
    assign steps_t = STEP_COUNT_BITS'(i_steps);

    always_comb begin
        cls.steps = i_steps;
        cls.rpm   = i_rpm;
        case (i_op)
            OP_TICK: cls.kind = K_TICK;
            OP_MOVE: cls.kind = (steps_t != '0 && i_rpm != '0) ? K_MOVE : K_NONE;
            OP_STOP: cls.kind = K_STOP;
            default: cls.kind = K_NONE;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign wr          = i_push && !o_full;
    assign rd          = i_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== src/stp_div.sv =====
// ============================================================================
// stp_div - half-period divider
// Restoring division of the fixed numerator by rpm*spr, one bit
// per cycle, result floored at the minimum half period.
// ============================================================================
module stp_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [stp_pkg::RPM_W-1:0] i_rpm,
    input  logic [stp_pkg::SPR_W-1:0] i_spr,
    output logic                      o_done,
    output logic [stp_pkg::HP_W-1:0]  o_half
);
    import stp_pkg::*;

    localparam int IDX_W = $clog2(HP_W);

    logic             r_run, r_done;
    logic [IDX_W-1:0] r_idx;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [HP_W-1:0]  r_quo;
    logic [RPM_W-1:0] rpm_e;
    logic [SPR_W-1:0] spr_e;
    logic [DEN_W:0]   rem_sh, diff;

    // zero operands count as one
    assign rpm_e  = (i_rpm == '0) ? RPM_W'(1) : i_rpm;
    assign spr_e  = (i_spr == '0) ? SPR_W'(1) : i_spr;
    assign rem_sh = {r_rem, HP_NUMER[r_idx]};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= DEN_W'(rpm_e) * DEN_W'(spr_e);
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_run) begin
            if (!diff[DEN_W]) begin
                r_rem <= diff[DEN_W-1:0];
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
            end
            r_quo <= {r_quo[HP_W-2:0], ~diff[DEN_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_idx <= IDX_W'(HP_W - 1);
            end else if (r_run) begin
                r_idx <= r_idx - IDX_W'(1);
                if (r_idx == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_half = (r_quo < HP_MIN) ? HP_MIN : r_quo;

endmodule

// ===== src/stp_back.sv =====
// ============================================================================
// stp_back - pulse sequencer
// Pending slot, setup/high/low phase machine, divider control and the
// result register that faces the output queue.
// ============================================================================
module stp_back #(
    parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF,
    parameter int DIR_SETUP_TICKS = stp_pkg::DIR_SETUP_TICKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  stp_pkg::t_cmd             i_cmd,
    output logic                      o_take,
    input  stp_pkg::t_cfg             i_cfg,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic                      o_step_out,
    output logic                      o_dir_out,
    output logic                      o_enable_n,
    output logic                      o_running,
    output logic [stp_pkg::REM_W-1:0] o_remaining
);
    import stp_pkg::*;

    localparam int N       = STEP_COUNT_BITS;
    localparam int SETUP_W = $clog2(DIR_SETUP_TICKS + 1);
    localparam int CNT_W   = (HP_W > SETUP_W) ? HP_W : SETUP_W;

    // sequencer state
    t_bstate          r_bst, n_bst;
    logic             r_pv, n_pv;
    logic             r_pm, n_pm;
    logic [N-1:0]     r_ps, n_ps;
    logic [RPM_W-1:0] r_pr, n_pr;
    t_phase           r_ph, n_ph;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [HP_W-1:0]  r_half, n_half;
    logic [N-1:0]     r_left, n_left;
    logic             r_dir, n_dir;
    logic             r_lvl, n_lvl;
    logic             r_busy, n_busy;

    // result register
    logic             r_ov;
    logic             r_o_step, r_o_dir, r_o_en_n, r_o_run;
    logic [REM_W-1:0] r_o_rem;

    logic             slot_free, need_div, div_start, out_wr, div_done;
    logic [HP_W-1:0]  div_half;
    logic             at_end;

    stp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rpm   (r_pr),
        .i_spr   (i_cfg.spr),
        .o_done  (div_done),
        .o_half  (div_half)
    );

    assign slot_free = !r_ov || i_pop;
    assign at_end    = (r_cnt == CNT_W'(1));
    // setup expiry with nothing waiting: the half period must be computed
    assign need_div  = (i_cmd.kind == K_TICK) && (r_ph == PH_SETUP) && at_end && !r_pv;

    // next state
    always_comb begin
        n_bst = r_bst;
        case (r_bst)
            BS_WAIT: begin
                if (i_cmd_valid && slot_free && need_div) begin
                    n_bst = BS_DIV;
                end
            end
            BS_DIV: begin
                if (div_done) begin
                    n_bst = BS_WAIT;
                end
            end
            default: n_bst = BS_WAIT;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_take    = 1'b0;
        div_start = 1'b0;
        out_wr    = 1'b0;
        case (r_bst)
            BS_WAIT: begin
                o_take    = i_cmd_valid && slot_free;
                div_start = o_take && need_div;
                out_wr    = o_take && !need_div;
            end
            BS_DIV: begin
                out_wr = div_done;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_pv   = r_pv;
        n_pm   = r_pm;
        n_ps   = r_ps;
        n_pr   = r_pr;
        n_ph   = r_ph;
        n_cnt  = r_cnt;
        n_half = r_half;
        n_left = r_left;
        n_dir  = r_dir;
        n_lvl  = r_lvl;
        n_busy = r_busy;

        if (r_bst == BS_WAIT && o_take) begin
            case (i_cmd.kind)
                K_TICK: begin
                    if (r_ph != PH_IDLE) begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                    case (r_ph)
                        PH_SETUP: begin
                            // with nothing waiting the divider takes over
                            if (at_end && r_pv) begin
                                n_ph = PH_IDLE;
                                n_lvl = 1'b0; n_busy = 1'b0;
                                n_left = '0;  n_cnt = '0;
                            end
                        end
                        PH_HIGH: begin
                            if (at_end) begin
                                n_lvl = 1'b0;
                                if (r_left != N'(1)) begin
                                    n_left = r_left - N'(1);
                                    n_ph   = PH_LOW;
                                    n_cnt  = CNT_W'(r_half);
                                end else begin
                                    n_ph = PH_IDLE;
                                    n_busy = 1'b0;
                                    n_left = '0; n_cnt = '0;
                                end
                            end
                        end
                        PH_LOW: begin
                            if (at_end) begin
                                if (r_pv) begin
                                    // waiting command aborts the move
                                    n_ph = PH_IDLE;
                                    n_lvl = 1'b0; n_busy = 1'b0;
                                    n_left = '0;  n_cnt = '0;
                                end else begin
                                    n_lvl = 1'b1;
                                    n_ph  = PH_HIGH;
                                    n_cnt = CNT_W'(r_half);
                                end
                            end
                        end
                        default: ;
                    endcase
                    // take the pending command once idle
                    if (n_ph == PH_IDLE && r_pv) begin
                        n_pv = 1'b0;
                        if (!r_pm) begin
                            n_busy = 1'b0;
                        end else begin
                            n_dir = ~r_ps[N-1];
                            n_ph  = PH_SETUP;
                            n_cnt = CNT_W'(DIR_SETUP_TICKS);
                        end
                    end
                end
                K_MOVE: begin
                    n_pv = 1'b1;
                    n_pm = 1'b1;
                    n_ps = N'(i_cmd.steps);
                    n_pr = i_cmd.rpm;
                end
                K_STOP: begin
                    n_pv = 1'b1;
                    n_pm = 1'b0;
                    n_ps = '0;
                    n_pr = '0;
                end
                default: ;
            endcase
        end

        // divider finished: start the first pulse
        if (r_bst == BS_DIV && div_done) begin
            n_half = div_half;
            n_left = r_ps[N-1] ? (~r_ps + N'(1)) : r_ps;
            n_busy = 1'b1;
            n_lvl  = 1'b1;
            n_ph   = PH_HIGH;
            n_cnt  = CNT_W'(div_half);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst  <= BS_WAIT;
            r_pv   <= 1'b0;
            r_pm   <= 1'b0;
            r_ps   <= '0;
            r_pr   <= '0;
            r_ph   <= PH_IDLE;
            r_cnt  <= '0;
            r_half <= '0;
            r_left <= '0;
            r_dir  <= 1'b0;
            r_lvl  <= 1'b0;
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_bst  <= n_bst;
            r_pv   <= n_pv;
            r_pm   <= n_pm;
            r_ps   <= n_ps;
            r_pr   <= n_pr;
            r_ph   <= n_ph;
            r_cnt  <= n_cnt;
            r_half <= n_half;
            r_left <= n_left;
            r_dir  <= n_dir;
            r_lvl  <= n_lvl;
            r_busy <= n_busy;
            if (out_wr) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_o_step <= n_lvl;
            r_o_dir  <= n_dir;
            r_o_en_n <= ~i_cfg.drv_en;
            r_o_run  <= n_busy;
            r_o_rem  <= REM_W'(n_left);
        end
    end

    assign o_empty     = !r_ov;
    assign o_step_out  = r_o_step;
    assign o_dir_out   = r_o_dir;
    assign o_enable_n  = r_o_en_n;
    assign o_running   = r_o_run;
    assign o_remaining = r_o_rem;

    a_busy_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("running with no steps left");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_IDLE) |-> (!r_lvl && !r_busy))
        else $error("idle phase with step high or running");

    a_level_in_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl |-> (r_ph == PH_HIGH))
        else $error("step pin high outside high phase");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_bst == BS_DIV))
        else $error("divider result with no waiting item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_wr && r_ov) |-> i_pop)
        else $error("result register overwritten");

endmodule

// ===== src/stepper_step_dir_pulse_generator_top.sv =====
// ============================================================================
// stepper_step_dir_pulse_generator_top - step/dir pulse generator
// Tick, move and stop beats in; one status beat out per input beat.
// ============================================================================
// Path: an accepted beat's result reaches the output queue through the queue
//   register, then the sequencer result register; the tick that ends the
//   direction setup of a move also waits for the divider first.
// Throughput: one beat per cycle while the result register has room, except
//   that setup-expiry tick, held while the 25-step restoring divider runs.
// Reset: synchronous, active low; sequencer idle, pending slot empty,
//   spr = 200, driver disabled, both queues empty.
// ============================================================================
module stepper_step_dir_pulse_generator_top #(
    parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF,
    parameter int DIR_SETUP_TICKS = stp_pkg::DIR_SETUP_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input beats
    input  logic                        push,
    output logic                        full,
    input  logic [stp_pkg::OP_W-1:0]    i_op,
    input  logic signed [stp_pkg::STEPS_W-1:0] i_steps,
    input  logic [stp_pkg::RPM_W-1:0]   i_rpm,
    // result beats
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_step_out,
    output logic                        o_dir_out,
    output logic                        o_enable_n,
    output logic                        o_running,
    output logic [stp_pkg::REM_W-1:0]   o_remaining,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import stp_pkg::*;

    t_cfg r_cfg;
    logic cfg_wr;
    logic cmd_valid, cmd_take;
    t_cmd cmd;

    // ------------------------------------------------------------------
    // Register file. Registers sit at 0 (spr) and 4
    // (driver_enable); only paddr[2] decodes. No wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spr    <= SPR_RESET;
            r_cfg.drv_en <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SPR:    r_cfg.spr    <= pwdata[SPR_W-1:0];
                REG_DRV_EN: r_cfg.drv_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SPR:    prdata = {{(32-SPR_W){1'b0}}, r_cfg.spr};
            REG_DRV_EN: prdata = {31'd0, r_cfg.drv_en};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front: classify the beat (zero moves and op 3 become no-ops) and
    // queue it. The queue lets pushes continue while the sequencer is
    // dividing or waiting on a full result register.
    // ------------------------------------------------------------------
    stp_front #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_steps     (i_steps),
        .i_rpm       (i_rpm),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_take      (cmd_take)
    );

    // ------------------------------------------------------------------
    // Back: pending slot and pulse phases. Most beats finish in the cycle
    // they are taken; the setup-expiry tick runs the divider first. The
    // result register is the output queue entry.
    // ------------------------------------------------------------------
    stp_back #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS),
        .DIR_SETUP_TICKS (DIR_SETUP_TICKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (cmd_take),
        .i_cfg       (r_cfg),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_step_out  (o_step_out),
        .o_dir_out   (o_dir_out),
        .o_enable_n  (o_enable_n),
        .o_running   (o_running),
        .o_remaining (o_remaining)
    );

endmodule

// ===== tb/stepper_step_dir_pulse_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// stepper_step_dir_pulse_generator_top_tb - self-checking bench of the pulse generator
// A directed table walks reset state, ignored beats, the most negative count,
// abort on stop and normal finish. Then six register settings follow, each
// with random move/stop/tick sequences. Every status beat is checked against
// a cycle-free model of the sequencer kept in the bench.
// ============================================================================
module stepper_step_dir_pulse_generator_top_tb;
    import stp_pkg::*;

    // op 3 is not decoded by the block; it must change nothing
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int     SETUP_TICKS   = DIR_SETUP_TICKS_DEF;
    localparam int     MAX_SHOWN     = 10;
    localparam int     LIVE_TARGET   = 1850;
    localparam int     N_CFG         = 6;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     SEQ_TICK_CAP  = 150;
    localparam longint TIMEOUT_NS    = 2_000_000;

    localparam logic [2:0] ADDR_SPR    = {REG_SPR, 2'b00};
    localparam logic [2:0] ADDR_DRV_EN = {REG_DRV_EN, 2'b00};

    // register settings of the random part; the last one is drawn at run time
    localparam logic [SPR_W-1:0] CFG_SPR [N_CFG] =
        '{16'hFFFF, 16'd0, 16'd200, 16'd1, 16'd20000, 16'd0};
    localparam bit CFG_DRV [N_CFG] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    typedef struct packed {
        logic             step;
        logic             dir;
        logic             en_n;
        logic             run;
        logic [REM_W-1:0] rem;
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STEPS_W-1:0] steps;
        logic [RPM_W-1:0]   rpm;
        logic [7:0]         reps;
        logic               typed;
        status_t            want;
    } stim_row_t;

    localparam status_t ST_NONE      = '0;
    localparam status_t ST_IDLE_REV  = '{1'b0, 1'b0, 1'b1, 1'b0, 16'd0};
    localparam status_t ST_IDLE_FWD  = '{1'b0, 1'b1, 1'b1, 1'b0, 16'd0};
    localparam status_t ST_FIRST_REV = '{1'b1, 1'b0, 1'b1, 1'b1, 16'h8000};

    // Directed table, run with steps_per_rev = 65535 so that the half period
    // is the 3-tick floor. Status is typed in where it is obvious.
    localparam int N_ROWS = 25;
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{OP_TICK,   16'h0000, 12'h000, 8'd1,  1'b1, ST_IDLE_REV},  // after reset
        '{OP_UNUSED, 16'h7FFF, 12'hFFF, 8'd1,  1'b1, ST_IDLE_REV},  // unknown op
        '{OP_MOVE,   16'h0000, 12'h064, 8'd1,  1'b1, ST_IDLE_REV},  // zero count dropped
        '{OP_MOVE,   16'h0005, 12'h000, 8'd1,  1'b1, ST_IDLE_REV},  // zero rpm dropped
        '{OP_STOP,   16'h1234, 12'hABC, 8'd1,  1'b1, ST_IDLE_REV},  // stop fields unused
        '{OP_TICK,   16'h55AA, 12'h5A5, 8'd1,  1'b1, ST_IDLE_REV},  // stop taken while idle
        '{OP_MOVE,   16'h8000, 12'hFFF, 8'd1,  1'b1, ST_IDLE_REV},  // most negative count
        '{OP_TICK,   16'hFFFF, 12'hFFF, 8'd1,  1'b1, ST_IDLE_REV},  // setup begins
        '{OP_TICK,   16'h0000, 12'h000, 8'd9,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd1,  1'b1, ST_FIRST_REV}, // 32768 steps left
        '{OP_MOVE,   16'h0003, 12'hFFF, 8'd1,  1'b0, ST_NONE},
        '{OP_STOP,   16'h0000, 12'h000, 8'd1,  1'b0, ST_NONE},      // overwrites the move
        '{OP_TICK,   16'h0000, 12'h000, 8'd3,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd2,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd1,  1'b1, ST_IDLE_REV},  // abort at pulse start
        '{OP_MOVE,   16'h0002, 12'hFFF, 8'd1,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd11, 1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd6,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd2,  1'b0, ST_NONE},
        '{OP_TICK,   16'h0000, 12'h000, 8'd1,  1'b1, ST_IDLE_FWD},  // finish, no low half
        '{OP_MOVE,   16'h0004, 12'hFFF, 8'd1,  1'b0, ST_NONE},
        '{OP_MOVE,   16'hFFFF, 12'hFFF, 8'd1,  1'b0, ST_NONE},      // overwrites the move
        '{OP_TICK,   16'h0000, 12'h000, 8'd1,  1'b0, ST_NONE},
        '{OP_STOP,   16'h0000, 12'h000, 8'd1,  1'b0, ST_NONE},      // stop during setup
        '{OP_TICK,   16'h0000, 12'h000, 8'd10, 1'b0, ST_NONE}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [OP_W-1:0]           i_op;
    logic signed [STEPS_W-1:0] i_steps;
    logic [RPM_W-1:0]          i_rpm;
    logic                      empty;
    logic                      pop;
    logic                      o_step_out;
    logic                      o_dir_out;
    logic                      o_enable_n;
    logic                      o_running;
    logic [REM_W-1:0]          o_remaining;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    stepper_step_dir_pulse_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_op        (i_op),
        .i_steps     (i_steps),
        .i_rpm       (i_rpm),
        .empty       (empty),
        .pop         (pop),
        .o_step_out  (o_step_out),
        .o_dir_out   (o_dir_out),
        .o_enable_n  (o_enable_n),
        .o_running   (o_running),
        .o_remaining (o_remaining),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Sequencer model: registers, pending slot, phase and pulse counters
    // ------------------------------------------------------------------------
    logic [SPR_W-1:0]   spr_q;
    logic               drv_en_q;
    logic               pend_vld;
    logic               pend_move;
    logic [STEPS_W-1:0] pend_steps;
    logic [RPM_W-1:0]   pend_rpm;
    t_phase             seq_ph;
    logic [HP_W-1:0]    tick_cnt;
    logic [HP_W-1:0]    half_per;
    logic [STEPS_W:0]   steps_left;   // one bit more: -32768 means 32768 steps
    logic               dir_q;
    logic               step_q;
    logic               busy_q;

    status_t exp_status_q[$];   // status beats still owed by the block
    int      miss_count;
    int      live_beats;        // accepted beats that are not simply ignored
    int      tx_beats;
    int      rx_beats;
    bit      tx_quiet;
    bit      rx_quiet;

    function automatic void go_idle();
        seq_ph     = PH_IDLE;
        step_q     = 1'b0;
        busy_q     = 1'b0;
        steps_left = '0;
        tick_cnt   = '0;
    endfunction

    // a command waiting at pulse start kills the move
    function automatic void start_pulse();
        if (pend_vld) begin
            go_idle();
            return;
        end
        step_q   = 1'b1;
        seq_ph   = PH_HIGH;
        tick_cnt = half_per;
    endfunction

    // end of direction setup: half period = 30e6 / (rpm * spr), floor 3
    function automatic void start_move();
        longint unsigned den;
        longint unsigned hp;
        den = (pend_rpm == '0) ? 64'd1 : 64'(pend_rpm);
        den = den * ((spr_q == '0) ? 64'd1 : 64'(spr_q));
        hp  = 64'(HP_NUMER) / den;
        if (hp < 64'(HP_MIN)) hp = 64'(HP_MIN);
        half_per   = hp[HP_W-1:0];
        steps_left = pend_steps[STEPS_W-1] ?
                     ({1'b1, {STEPS_W{1'b0}}} - {1'b0, pend_steps}) : {1'b0, pend_steps};
        busy_q     = 1'b1;
        start_pulse();
    endfunction

    function automatic void take_cmd();
        pend_vld = 1'b0;
        if (!pend_move || pend_steps == '0) begin
            busy_q = 1'b0;
            return;
        end
        dir_q    = ~pend_steps[STEPS_W-1];
        seq_ph   = PH_SETUP;
        tick_cnt = HP_W'(SETUP_TICKS);
    endfunction

    function automatic void advance_tick();
        case (seq_ph)
            PH_SETUP: begin
                if (tick_cnt != '0) tick_cnt = tick_cnt - 1'b1;
                if (tick_cnt == '0) start_move();
            end
            PH_HIGH: begin
                if (tick_cnt != '0) tick_cnt = tick_cnt - 1'b1;
                if (tick_cnt == '0) begin
                    step_q = 1'b0;
                    if (steps_left != '0) steps_left = steps_left - 1'b1;
                    if (steps_left != '0) begin
                        seq_ph   = PH_LOW;
                        tick_cnt = half_per;
                    end else begin
                        go_idle();
                    end
                end
            end
            PH_LOW: begin
                if (tick_cnt != '0) tick_cnt = tick_cnt - 1'b1;
                if (tick_cnt == '0) start_pulse();
            end
            default: ;
        endcase
        // finish or abort frees the sequencer; a waiting command goes on this tick
        if (seq_ph == PH_IDLE && pend_vld) take_cmd();
    endfunction

    function automatic status_t predict_status(input logic [OP_W-1:0] op,
                                               input logic [STEPS_W-1:0] steps,
                                               input logic [RPM_W-1:0] rpm);
        case (op)
            OP_TICK: advance_tick();
            OP_MOVE: begin
                if (steps != '0 && rpm != '0) begin
                    pend_vld   = 1'b1;
                    pend_move  = 1'b1;
                    pend_steps = steps;
                    pend_rpm   = rpm;
                end
            end
            OP_STOP: begin
                pend_vld   = 1'b1;
                pend_move  = 1'b0;
                pend_steps = '0;
                pend_rpm   = '0;
            end
            default: ;
        endcase
        return '{step_q, dir_q, ~drv_en_q, busy_q, steps_left[REM_W-1:0]};
    endfunction

    // ------------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------------
    // mostly short moves; now and then a long one that gets aborted
    function automatic logic [STEPS_W-1:0] pick_steps();
        int          r;
        int unsigned mag;
        r = $urandom_range(0, 99);
        if (r == 90) return 16'h8000;
        if (r == 91) return 16'h7FFF;
        if (r > 91) return STEPS_W'($urandom());
        mag = (r < 75) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        return $urandom_range(0, 1) ? STEPS_W'(mag) : STEPS_W'(-mag);
    endfunction

    // keep the half period near 20 ticks or less where spr allows it
    function automatic logic [RPM_W-1:0] pick_rpm(input bit hold);
        int unsigned spr_e;
        int unsigned lo;
        if (hold) begin
            case ($urandom_range(0, 3))
                0:       return 12'd1;
                1:       return 12'hFFF;
                default: return RPM_W'($urandom_range(1, 4095));
            endcase
        end
        spr_e = (spr_q == '0) ? 1 : spr_q;
        lo    = 1500000 / spr_e;
        if (lo < 1) lo = 1;
        if (lo > 4095) lo = 4095;
        return RPM_W'($urandom_range(lo, 4095));
    endfunction

    // ------------------------------------------------------------------------
    // Beat driver: inputs change at the falling edge, handshake seen at rising
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [STEPS_W-1:0] steps,
                             input logic [RPM_W-1:0] rpm, input bit typed = 1'b0,
                             input status_t want = '0);
        int      gap;
        status_t model;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push    <= 1'b1;
        i_op    <= op;
        i_steps <= steps;
        i_rpm   <= rpm;
        do @(posedge i_clk); while (full);
        model = predict_status(op, steps, rpm);
        exp_status_q.push_back(typed ? want : model);
        if (!(op == OP_UNUSED || (op == OP_MOVE && (steps == '0 || rpm == '0))))
            live_beats++;
        tx_beats++;
        if (tx_beats % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // drop push and wait until every owed status beat has come back
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (exp_status_q.size() != 0) @(posedge i_clk);
    endtask

    // APB write: setup then access; pready is sampled on the access edge
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SPR) spr_q = data[SPR_W-1:0];
        else drv_en_q = data[0];
    endtask

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Status sink: random pop gaps, each beat checked against the oldest owed
    // ------------------------------------------------------------------------
    initial begin : status_sink
        int      gap;
        status_t got;
        status_t want;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                @(negedge i_clk);
                pop <= 1'b0;
            end
            @(negedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = {o_step_out, o_dir_out, o_enable_n, o_running, o_remaining};
            if (exp_status_q.size() == 0) begin
                miss_count++;
                if (miss_count <= MAX_SHOWN)
                    $display("extra beat: step %0b dir %0b en_n %0b run %0b rem %0d",
                             got.step, got.dir, got.en_n, got.run, got.rem);
            end else begin
                want = exp_status_q.pop_front();
                if (got !== want) begin
                    miss_count++;
                    if (miss_count <= MAX_SHOWN) begin
                        $display("beat %0d exp: step %0b dir %0b en_n %0b run %0b rem %0d",
                                 rx_beats, want.step, want.dir, want.en_n, want.run,
                                 want.rem);
                        $display("beat %0d act: step %0b dir %0b en_n %0b run %0b rem %0d",
                                 rx_beats, got.step, got.dir, got.en_n, got.run, got.rem);
                    end
                end
            end
            rx_beats++;
            if (rx_beats % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int               r;
        int               ticks;
        int               goal;
        int               mid;
        bit               hold;
        logic [SPR_W-1:0] spr_set;
        bit               drv_set;

        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_op       = OP_TICK;
        i_steps    = '0;
        i_rpm      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        miss_count = 0;
        live_beats = 0;
        tx_beats   = 0;
        rx_beats   = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;

        // model state after reset
        spr_q      = SPR_RESET;
        drv_en_q   = 1'b0;
        pend_vld   = 1'b0;
        pend_move  = 1'b0;
        pend_steps = '0;
        pend_rpm   = '0;
        seq_ph     = PH_IDLE;
        tick_cnt   = '0;
        half_per   = '0;
        steps_left = '0;
        dir_q      = 1'b0;
        step_q     = 1'b0;
        busy_q     = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the fastest half period, driver still disabled
        write_reg(ADDR_SPR, 32'h0000_FFFF);
        for (int i = 0; i < N_ROWS; i++) begin
            repeat (DIR_ROWS[i].reps)
                send_beat(DIR_ROWS[i].op, DIR_ROWS[i].steps, DIR_ROWS[i].rpm,
                          DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // random part: one register setting per stretch, written while drained
        for (int c = 0; c < N_CFG; c++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            spr_set = (c == N_CFG - 1) ? SPR_W'($urandom_range(2000, 65535)) : CFG_SPR[c];
            drv_set = (c == N_CFG - 1) ? bit'($urandom_range(0, 1)) : CFG_DRV[c];
            write_reg(ADDR_SPR, {16'h0000, spr_set});
            write_reg(ADDR_DRV_EN, {31'd0, drv_set});

            // tiny spr gives half periods of thousands of ticks: there every
            // move is aborted by a command that lands during direction setup
            hold = (spr_q < 16'd100);
            goal = live_beats + (LIVE_TARGET - live_beats) / (N_CFG - c);
            mid  = (live_beats + goal) / 2;

            while (live_beats < goal) begin
                if ($urandom_range(0, 99) < 5) send_beat(OP_STOP, STEPS_W'($urandom()),
                                                         RPM_W'($urandom()));
                else send_beat(OP_MOVE, pick_steps(), pick_rpm(hold));
                ticks = 0;
                while (seq_ph != PH_IDLE || pend_vld) begin
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        // noise the block must ignore
                        case ($urandom_range(0, 2))
                            0: send_beat(OP_UNUSED, STEPS_W'($urandom()), RPM_W'($urandom()));
                            1: send_beat(OP_MOVE, '0, RPM_W'($urandom()));
                            default: send_beat(OP_MOVE, STEPS_W'($urandom()), '0);
                        endcase
                    end else if (!pend_vld &&
                                 (hold ? (seq_ph == PH_SETUP && (tick_cnt <= 1 || r < 30))
                                       : (ticks > SEQ_TICK_CAP || r < 8))) begin
                        // abort: a stop, or a new move that replaces the current one
                        if ($urandom_range(0, 2) == 0)
                            send_beat(OP_MOVE, pick_steps(), pick_rpm(hold));
                        else
                            send_beat(OP_STOP, STEPS_W'($urandom()), RPM_W'($urandom()));
                    end else begin
                        send_beat(OP_TICK, STEPS_W'($urandom()), RPM_W'($urandom()));
                        ticks++;
                    end
                end
                // once per setting the sender waits for the result side to empty
                if (live_beats >= mid && mid != 0) begin
                    drain_results();
                    mid = 0;
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (miss_count == 0 && exp_status_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
